[src/vae_pkg.sv]
// Shared types and constants for the voice ADSR envelope bank.
// Holds the command codes, voice stages, register indexes and the structs
// that pass between the front, the back and the output stage.
package vae_pkg;

	localparam int LEVEL_W    = 16;
	localparam int TIMER_W    = 24;
	localparam int NOTE_W     = 4;
	localparam int CMD_W      = 2;
	localparam int STAGE_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [TIMER_W-1:0] timer_t;

	localparam level_t LEVEL_MAX      = '1;
	localparam timer_t TIMER_MAX      = '1;
	localparam level_t SUSTAIN_RST    = 16'd49152;
	localparam timer_t AUTO_TICKS_RST = 24'd48000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2,
		CMD_ALL_OFF  = 2'd3
	} cmd_code_t;

	typedef enum logic [STAGE_W-1:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK_STEP  = 3'd0,
		REG_DECAY_STEP   = 3'd1,
		REG_SUSTAIN      = 3'd2,
		REG_RELEASE_STEP = 3'd3,
		REG_FIXED_MODE   = 3'd4,
		REG_AUTO_TICKS   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		BK_FETCH = 1'b0,
		BK_SWEEP = 1'b1
	} back_state_t;

	typedef struct packed {
		level_t attack_step;
		level_t decay_step;
		level_t sustain_level;
		level_t release_step;
		logic   fixed_mode;
		timer_t auto_ticks;
	} cfg_t;

	typedef struct packed {
		cmd_code_t         op;
		logic [NOTE_W-1:0] note;
		level_t            volume;
	} cmd_item_t;

	typedef struct packed {
		logic [NOTE_W-1:0] voice;
		level_t            env;
		level_t            vol;
		stage_t            stage;
		logic              last;
	} rpt_t;

endpackage

[src/vae_cmd_if.sv]
// Command channel of the envelope bank: valid/ready with one command item.
// Depends on vae_pkg for the field widths.
interface vae_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [vae_pkg::CMD_W-1:0]  command;
	logic [vae_pkg::NOTE_W-1:0] note;
	logic [vae_pkg::LEVEL_W-1:0] volume;

	modport source(output valid, command, note, volume, input ready);
	modport sink(input valid, command, note, volume, output ready);
endinterface

[src/vae_res_if.sv]
// Result channel of the envelope bank: valid/ready with one voice report.
// Depends on vae_pkg for the field widths.
interface vae_res_if;
	logic                        valid;
	logic                        ready;
	logic [vae_pkg::NOTE_W-1:0]  voice;
	logic [vae_pkg::LEVEL_W-1:0] level;
	logic [vae_pkg::STAGE_W-1:0] stage;
	logic                        last;

	modport source(output valid, voice, level, stage, last, input ready);
	modport sink(input valid, voice, level, stage, last, output ready);
endinterface

[src/vae_front.sv]
// Front of the envelope bank: takes command transactions, drops note commands
// for voices that do not exist and queues the rest in a two-entry FIFO.
// Depends on vae_pkg and vae_cmd_if.
module vae_front #(
	parameter int NUM_VOICES = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	vae_cmd_if.sink            cmd,
	output logic               q_valid,
	output vae_pkg::cmd_item_t q_item,
	input  logic               q_pop
);

	vae_pkg::cmd_item_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	vae_pkg::cmd_code_t code;
	logic               keep;
	logic               push;

	assign code = vae_pkg::cmd_code_t'(cmd.command);
	assign keep = (code == vae_pkg::CMD_TICK) || (code == vae_pkg::CMD_ALL_OFF) ||
		(32'(cmd.note) < NUM_VOICES);

	assign cmd.ready = (count_q != 2'd2);
	assign push      = cmd.valid && cmd.ready && keep;
	assign q_valid   = (count_q != 2'd0);
	assign q_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{op: code, note: cmd.note, volume: cmd.volume};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/vae_back.sv]
// Back of the envelope bank: per-voice state and the sequencer that applies
// queued commands and steps the voices one per cycle on a tick while not stalled.
// Depends on vae_pkg; feeds voice reports to vae_out.
module vae_back #(
	parameter int NUM_VOICES = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vae_pkg::cfg_t      cfg,
	input  logic               q_valid,
	input  vae_pkg::cmd_item_t q_item,
	output logic               q_pop,
	output logic               rpt_valid,
	output vae_pkg::rpt_t      rpt,
	input  logic               rpt_take
);

	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam logic [VW-1:0] LAST_IDX = VW'(NUM_VOICES - 1);

	vae_pkg::back_state_t state_q, state_d;

	vae_pkg::stage_t stage_q [NUM_VOICES];
	vae_pkg::level_t env_q [NUM_VOICES];
	vae_pkg::level_t vol_q [NUM_VOICES];
	vae_pkg::timer_t ticks_q [NUM_VOICES];
	logic [NUM_VOICES-1:0] held_q;
	logic [NUM_VOICES-1:0] arel_q;
	logic [VW-1:0]         ptr_q;

	logic          rpt_valid_s1;
	vae_pkg::rpt_t rpt_s1;

	logic [VW-1:0]   addr;
	vae_pkg::stage_t cur_stage;
	vae_pkg::level_t cur_env;
	vae_pkg::timer_t cur_ticks;
	logic            cur_held;
	logic            cur_arel;
	logic            cur_busy;

	logic            s1_free;
	logic            step_done;
	logic            advance;
	logic            later_busy;

	vae_pkg::stage_t new_stage;
	vae_pkg::level_t new_env;
	vae_pkg::timer_t new_ticks;
	logic            new_arel;
	logic [vae_pkg::LEVEL_W:0] att_sum;
	logic [vae_pkg::LEVEL_W:0] dec_floor;

	vae_pkg::stage_t press_stage;
	vae_pkg::timer_t press_ticks;
	logic            press_arel;

	// One shared address: the sweep pointer on a tick, the note otherwise
	assign addr      = (state_q == vae_pkg::BK_SWEEP) ? ptr_q : VW'(q_item.note);
	assign cur_stage = stage_q[addr];
	assign cur_env   = env_q[addr];
	assign cur_ticks = ticks_q[addr];
	assign cur_held  = held_q[addr];
	assign cur_arel  = arel_q[addr];
	assign cur_busy  = (cur_stage != vae_pkg::ST_IDLE);
	assign s1_free   = !rpt_valid_s1 || rpt_take;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vae_pkg::BK_FETCH: begin
				if (q_valid && (q_item.op == vae_pkg::CMD_TICK)) begin
					state_d = vae_pkg::BK_SWEEP;
				end
			end
			vae_pkg::BK_SWEEP: begin
				if (step_done && (ptr_q == LAST_IDX)) begin
					state_d = vae_pkg::BK_FETCH;
				end
			end
			default: state_d = vae_pkg::BK_FETCH;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_pop     = 1'b0;
		step_done = 1'b0;
		advance   = 1'b0;
		unique case (state_q)
			vae_pkg::BK_FETCH: q_pop = q_valid;
			vae_pkg::BK_SWEEP: begin
				step_done = !cur_busy || s1_free;
				advance   = cur_busy && s1_free;
			end
			default: q_pop = 1'b0;
		endcase
	end

	// Any voice above the pointer still to report in this tick
	always_comb begin
		later_busy = 1'b0;
		for (int i = 0; i < NUM_VOICES; i++) begin
			if ((VW'(i) > ptr_q) && (stage_q[i] != vae_pkg::ST_IDLE)) begin
				later_busy = 1'b1;
			end
		end
	end

	// One tick of the voice at the pointer
	always_comb begin
		new_ticks = (cur_held && (cur_ticks != vae_pkg::TIMER_MAX)) ?
			cur_ticks + 1'b1 : cur_ticks;
		new_stage = cur_stage;
		new_env   = cur_env;
		new_arel  = cur_arel;
		att_sum   = {1'b0, cur_env} + {1'b0, cfg.attack_step};
		dec_floor = {1'b0, cfg.sustain_level} + {1'b0, cfg.decay_step};
		unique case (cur_stage)
			vae_pkg::ST_ATTACK: begin
				if ((cfg.attack_step == '0) || (att_sum >= {1'b0, vae_pkg::LEVEL_MAX})) begin
					new_env   = vae_pkg::LEVEL_MAX;
					new_stage = cur_held ? vae_pkg::ST_DECAY : vae_pkg::ST_RELEASE;
				end else begin
					new_env = att_sum[vae_pkg::LEVEL_W-1:0];
				end
			end
			vae_pkg::ST_DECAY: begin
				if ((cfg.decay_step == '0) || ({1'b0, cur_env} <= dec_floor)) begin
					new_env   = cfg.sustain_level;
					new_stage = cur_held ? vae_pkg::ST_SUSTAIN : vae_pkg::ST_RELEASE;
				end else begin
					new_env = cur_env - cfg.decay_step;
				end
			end
			vae_pkg::ST_SUSTAIN: begin
				new_env = cfg.sustain_level;
				if (!cur_held || (cfg.fixed_mode && (new_ticks >= cfg.auto_ticks))) begin
					new_stage = vae_pkg::ST_RELEASE;
					if (cfg.fixed_mode && cur_held) begin
						new_arel = 1'b1;
					end
				end
			end
			vae_pkg::ST_RELEASE: begin
				if ((cfg.release_step == '0) || (cur_env <= cfg.release_step)) begin
					new_env   = '0;
					new_stage = vae_pkg::ST_IDLE;
				end else begin
					new_env = cur_env - cfg.release_step;
				end
			end
			default: new_stage = cur_stage;
		endcase
	end

	// Note on: a fresh press restarts the voice; a held key retriggers from
	// release or idle unless the voice auto released in fixed mode
	always_comb begin
		press_stage = cur_stage;
		press_ticks = cur_ticks;
		press_arel  = cur_arel;
		if (!cur_held) begin
			press_stage = vae_pkg::ST_ATTACK;
			press_ticks = '0;
			press_arel  = 1'b0;
		end else if (((cur_stage == vae_pkg::ST_RELEASE) || (cur_stage == vae_pkg::ST_IDLE)) &&
				(!cfg.fixed_mode || !cur_arel)) begin
			press_stage = vae_pkg::ST_ATTACK;
			press_arel  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vae_pkg::BK_FETCH;
			ptr_q        <= '0;
			held_q       <= '0;
			arel_q       <= '0;
			rpt_valid_s1 <= 1'b0;
			for (int i = 0; i < NUM_VOICES; i++) begin
				stage_q[i] <= vae_pkg::ST_IDLE;
				env_q[i]   <= '0;
				vol_q[i]   <= '0;
				ticks_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				unique case (q_item.op)
					vae_pkg::CMD_TICK: ptr_q <= '0;
					vae_pkg::CMD_NOTE_ON: begin
						held_q[addr]  <= 1'b1;
						vol_q[addr]   <= q_item.volume;
						stage_q[addr] <= press_stage;
						ticks_q[addr] <= press_ticks;
						arel_q[addr]  <= press_arel;
					end
					vae_pkg::CMD_NOTE_OFF: begin
						held_q[addr] <= 1'b0;
						if (cur_stage == vae_pkg::ST_SUSTAIN) begin
							stage_q[addr] <= vae_pkg::ST_RELEASE;
						end
					end
					default: begin
						held_q <= '0;
						for (int i = 0; i < NUM_VOICES; i++) begin
							if (stage_q[i] != vae_pkg::ST_IDLE) begin
								stage_q[i] <= vae_pkg::ST_RELEASE;
							end
						end
					end
				endcase
			end
			if (advance) begin
				stage_q[addr] <= new_stage;
				env_q[addr]   <= new_env;
				ticks_q[addr] <= new_ticks;
				arel_q[addr]  <= new_arel;
			end
			if (step_done) begin
				ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
			end
			if (advance) begin
				rpt_valid_s1 <= 1'b1;
			end else if (rpt_take) begin
				rpt_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rpt_s1 <= '{voice: vae_pkg::NOTE_W'(addr), env: new_env, vol: vol_q[addr],
				stage: new_stage, last: !later_busy};
		end
	end

	assign rpt_valid = rpt_valid_s1;
	assign rpt       = rpt_s1;

endmodule

[src/vae_out.sv]
// Output stage of the envelope bank: scales each voice report by its volume
// and holds the result until the receiver takes it.
// Depends on vae_pkg and vae_res_if.
module vae_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rpt_valid,
	input  vae_pkg::rpt_t rpt,
	output logic          rpt_take,
	vae_res_if.source     res
);

	logic                          res_valid_q;
	logic [vae_pkg::NOTE_W-1:0]    voice_q;
	vae_pkg::level_t               level_q;
	vae_pkg::stage_t               stage_q;
	logic                          last_q;
	logic [2*vae_pkg::LEVEL_W-1:0] product;

	assign rpt_take = rpt_valid && (!res_valid_q || res.ready);
	assign product  = rpt.env * rpt.vol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rpt_take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_take) begin
			voice_q <= rpt.voice;
			level_q <= product[2*vae_pkg::LEVEL_W-1:vae_pkg::LEVEL_W];
			stage_q <= rpt.stage;
			last_q  <= rpt.last;
		end
	end

	assign res.valid = res_valid_q;
	assign res.voice = voice_q;
	assign res.level = level_q;
	assign res.stage = vae_pkg::STAGE_W'(stage_q);
	assign res.last  = last_q;

endmodule

[src/voice_adsr_envelope_bank.sv]
// Bank of ADSR envelope voices, one per note, stepped one sample per tick.
// Command channel (cmd): tick, note on, note off, all notes off. Note commands
// for a voice index at or above NUM_VOICES are taken and dropped.
// Result channel (res): one transaction per voice that was sounding when the
// tick began, in voice order: its level (envelope times volume, upper half of
// the product), its stage after the tick, and last on the final one. A tick
// with no sounding voice gives no transaction; other commands give none.
// Commands enter a two-entry queue. Note on, note off and all notes off are
// applied in the sequencer as they are popped; a tick sweeps every voice slot
// in order through the single shared envelope step unit, and the sequencer
// pops no further command until the sweep ends. Each report passes the report
// stage and then the output register.
// A stalled receiver holds the output register, then the report stage, then
// the voice sweep; the queue keeps taking commands until it is full.
// Reset clears every voice to idle with zero level, volume and timer, and
// loads the register defaults. Write the registers (cfg_we, cfg_idx,
// cfg_wdata) only while no command is in progress.
// Depends on vae_pkg, vae_cmd_if, vae_res_if, vae_front, vae_back, vae_out.
module voice_adsr_envelope_bank #(
	parameter int NUM_VOICES = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vae_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [vae_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	vae_cmd_if.sink                          cmd,
	vae_res_if.source                        res
);

	vae_pkg::cfg_t      cfg_q;
	logic               q_valid;
	vae_pkg::cmd_item_t q_item;
	logic               q_pop;
	logic               rpt_valid;
	vae_pkg::rpt_t      rpt;
	logic               rpt_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_step   <= '0;
			cfg_q.decay_step    <= '0;
			cfg_q.sustain_level <= vae_pkg::SUSTAIN_RST;
			cfg_q.release_step  <= '0;
			cfg_q.fixed_mode    <= 1'b0;
			cfg_q.auto_ticks    <= vae_pkg::AUTO_TICKS_RST;
		end else if (cfg_we) begin
			unique case (vae_pkg::reg_idx_t'(cfg_idx))
				vae_pkg::REG_ATTACK_STEP:  cfg_q.attack_step   <= cfg_wdata[vae_pkg::LEVEL_W-1:0];
				vae_pkg::REG_DECAY_STEP:   cfg_q.decay_step    <= cfg_wdata[vae_pkg::LEVEL_W-1:0];
				vae_pkg::REG_SUSTAIN:      cfg_q.sustain_level <= cfg_wdata[vae_pkg::LEVEL_W-1:0];
				vae_pkg::REG_RELEASE_STEP: cfg_q.release_step  <= cfg_wdata[vae_pkg::LEVEL_W-1:0];
				vae_pkg::REG_FIXED_MODE:   cfg_q.fixed_mode    <= cfg_wdata[0];
				vae_pkg::REG_AUTO_TICKS:   cfg_q.auto_ticks    <= cfg_wdata[vae_pkg::TIMER_W-1:0];
				default:                   cfg_q               <= cfg_q;
			endcase
		end
	end

	vae_front #(
		.NUM_VOICES(NUM_VOICES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	vae_back #(
		.NUM_VOICES(NUM_VOICES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.rpt_valid (rpt_valid),
		.rpt       (rpt),
		.rpt_take  (rpt_take)
	);

	vae_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.rpt_valid (rpt_valid),
		.rpt       (rpt),
		.rpt_take  (rpt_take),
		.res       (res)
	);

	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("command queue popped while empty");

	// Reports only name voices that exist
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (32'(res.voice) < NUM_VOICES))
		else $error("report for a voice out of range");

	// A voice reported as gone idle is silent
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.stage == vae_pkg::STAGE_W'(vae_pkg::ST_IDLE))) |-> (res.level == '0))
		else $error("idle voice reported with non-zero level");

	// A report enters the output register only when the register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_take && res.valid) |-> res.ready)
		else $error("output register overwritten while stalled");

endmodule
